// File: hdl/ocmon_pkg.sv
// Shared types and constants for the three channel overcurrent monitor.
// Used by ocmon_lane, ocmon_merge and the top level; depends on nothing.
package ocmon_pkg;

  localparam int AMPS_W      = 20;
  localparam int CNT_W       = 8;
  localparam int THR_W       = 12;
  localparam int CFG_W       = 20;
  localparam int IDX_W       = 2;
  localparam int NUM_CH      = 3;
  localparam int LANE_STAGES = 4;

  localparam int CH_DC_FIRST  = 0;
  localparam int CH_DC_SECOND = 1;
  localparam int CH_INVERTER  = 2;

  localparam int GAIN      = 1419;
  localparam int GAIN_W    = 11;
  localparam int OFFSET    = 700;
  localparam int DC_DEN    = 1750;
  localparam int INV_DEN   = 175;
  localparam int DC_SHIFT  = 8;
  localparam int INV_SHIFT = 9;

  localparam logic [AMPS_W-1:0] AMPS_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

  localparam logic [IDX_W-1:0] REG_DISCONNECT = 2'd0;
  localparam logic [IDX_W-1:0] REG_DC_LIMIT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_INV_LIMIT  = 2'd2;
  localparam logic [IDX_W-1:0] REG_CONSEC     = 2'd3;

  localparam logic [THR_W-1:0]  RST_DISCONNECT = '0;
  localparam logic [AMPS_W-1:0] RST_DC_LIMIT   = '1;
  localparam logic [AMPS_W-1:0] RST_INV_LIMIT  = '1;
  localparam logic [CNT_W-1:0]  RST_CONSEC     = 8'd3;

  typedef logic [AMPS_W-1:0] amps_t;

  typedef struct packed {
    logic [AMPS_W-1:0] dc_limit;
    logic [AMPS_W-1:0] inv_limit;
    logic [CNT_W-1:0]  consec_limit;
  } ocmon_limits_t;

endpackage

// File: hdl/ocmon_lane.sv
// One conversion lane: ADC code to current magnitude, four register stages.
// Divide by constant as reciprocal multiply plus one correction step.
// Depends on ocmon_pkg.
module ocmon_lane #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 8,
  parameter bit INV       = 1'b0
) (
  input  logic                                   clk,
  input  logic [ocmon_pkg::LANE_STAGES-1:0]      adv,
  input  logic [ADC_BITS-1:0]                    raw,
  input  logic [ocmon_pkg::THR_W-1:0]            thr,
  output ocmon_pkg::amps_t                       amps
);

  localparam int DW = ADC_BITS + ocmon_pkg::GAIN_W;
  localparam int SH = (INV ? ocmon_pkg::INV_SHIFT : ocmon_pkg::DC_SHIFT) + FRAC_BITS;
  localparam longint unsigned FS  = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned DIV = (INV ? ocmon_pkg::INV_DEN : ocmon_pkg::DC_DEN) * FS;
  localparam longint unsigned OFS = ocmon_pkg::OFFSET * FS;
  localparam longint unsigned MUL = (64'd1 << (SH + DW)) / DIV;
  localparam int MW  = $clog2(MUL + 1);
  localparam int DVW = $clog2(DIV + 1);
  localparam int PW  = DW + MW;
  localparam int RW  = MW + DVW;
  localparam int QW  = MW + 1;
  localparam int CW  = (QW > ocmon_pkg::AMPS_W) ? QW : ocmon_pkg::AMPS_W + 1;
  localparam int TW  = (ADC_BITS > ocmon_pkg::THR_W) ? ADC_BITS : ocmon_pkg::THR_W;

  logic [DW-1:0]    a;
  logic [DW-1:0]    d_nxt;
  logic             disc_nxt;
  logic [DW-1:0]    d1_r;
  logic             disc1_r;
  logic [PW-1:0]    prod;
  logic [MW-1:0]    qe2_r;
  logic [DW-1:0]    d2_r;
  logic             disc2_r;
  logic [RW-1:0]    m3_r;
  logic [MW-1:0]    qe3_r;
  logic [DW-1:0]    d3_r;
  logic             disc3_r;
  logic [RW-1:0]    x;
  logic [RW-1:0]    rem;
  logic [QW-1:0]    q;
  logic [CW-1:0]    q_ext;
  ocmon_pkg::amps_t amps_nxt;
  ocmon_pkg::amps_t amps_r;

  always_comb begin
    a        = DW'(raw) * DW'(ocmon_pkg::GAIN);
    d_nxt    = (a >= DW'(OFS)) ? (a - DW'(OFS)) : (DW'(OFS) - a);
    disc_nxt = TW'(raw) < TW'(thr);
  end

  assign prod = PW'(d1_r) * PW'(MUL);

  always_comb begin
    x     = RW'({d3_r, {SH{1'b0}}});
    rem   = x - m3_r;
    q     = QW'(qe3_r) + QW'(rem >= RW'(DIV));
    q_ext = CW'(q);
    if (disc3_r) begin
      amps_nxt = '0;
    end else if (q_ext > CW'(ocmon_pkg::AMPS_MAX)) begin
      amps_nxt = ocmon_pkg::AMPS_MAX;
    end else begin
      amps_nxt = ocmon_pkg::AMPS_W'(q_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_r    <= d_nxt;
      disc1_r <= disc_nxt;
    end
    if (adv[1]) begin
      qe2_r   <= prod[PW-1:DW];
      d2_r    <= d1_r;
      disc2_r <= disc1_r;
    end
    if (adv[2]) begin
      m3_r    <= RW'(qe2_r) * RW'(DIV);
      qe3_r   <= qe2_r;
      d3_r    <= d2_r;
      disc3_r <= disc2_r;
    end
    if (adv[3]) begin
      amps_r <= amps_nxt;
    end
  end

  assign amps = amps_r;

endmodule

// File: hdl/ocmon_merge.sv
// Merge stage: per-channel run counters, limit compare and trip, output register.
// Depends on ocmon_pkg.
module ocmon_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  ocmon_pkg::amps_t         amps_in [ocmon_pkg::NUM_CH],
  input  ocmon_pkg::ocmon_limits_t lim,
  output ocmon_pkg::amps_t         amps_out [ocmon_pkg::NUM_CH],
  output logic                     trip
);

  logic [ocmon_pkg::CNT_W-1:0]  cnt_r   [ocmon_pkg::NUM_CH];
  logic [ocmon_pkg::CNT_W-1:0]  cnt_nxt [ocmon_pkg::NUM_CH];
  logic [ocmon_pkg::NUM_CH-1:0] hit;
  ocmon_pkg::amps_t             limit   [ocmon_pkg::NUM_CH];
  ocmon_pkg::amps_t             amps_r  [ocmon_pkg::NUM_CH];
  logic                         trip_r;
  logic                         over;

  always_comb begin
    for (int ch = 0; ch < ocmon_pkg::NUM_CH; ch++) begin
      limit[ch] = (ch == ocmon_pkg::CH_INVERTER) ? lim.inv_limit : lim.dc_limit;
      over      = amps_in[ch] > limit[ch];
      if (!over) begin
        cnt_nxt[ch] = '0;
      end else if (cnt_r[ch] == ocmon_pkg::COUNT_MAX) begin
        cnt_nxt[ch] = cnt_r[ch];
      end else begin
        cnt_nxt[ch] = cnt_r[ch] + ocmon_pkg::CNT_W'(1);
      end
      hit[ch] = over && (cnt_nxt[ch] >= lim.consec_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < ocmon_pkg::NUM_CH; ch++) begin
        cnt_r[ch] <= '0;
      end
    end else if (load) begin
      for (int ch = 0; ch < ocmon_pkg::NUM_CH; ch++) begin
        cnt_r[ch] <= cnt_nxt[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int ch = 0; ch < ocmon_pkg::NUM_CH; ch++) begin
        amps_r[ch] <= amps_in[ch];
      end
      trip_r <= |hit;
    end
  end

  assign amps_out = amps_r;
  assign trip     = trip_r;

endmodule

// File: hdl/three_channel_overcurrent_monitor_top.sv
// Three channel overcurrent monitor: three conversion lanes and a merge stage.
// Words pass the four lane stages, then the merge output register.
// One word per cycle if not stalled; a lane is a 4-stage constant-divide pipe.
// Reset (rst_n low, synchronous) clears stage valids and run counters; config
// registers take defaults. Depends on ocmon_pkg, ocmon_lane and ocmon_merge.
module three_channel_overcurrent_monitor_top #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ADC_BITS-1:0]             in_raw_dc_first,
  input  logic [ADC_BITS-1:0]             in_raw_dc_second,
  input  logic [ADC_BITS-1:0]             in_raw_inverter,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ocmon_pkg::AMPS_W-1:0]    out_amps_dc_first,
  output logic [ocmon_pkg::AMPS_W-1:0]    out_amps_dc_second,
  output logic [ocmon_pkg::AMPS_W-1:0]    out_amps_inverter,
  output logic                            out_trip,
  input  logic                            cfg_we,
  input  logic [ocmon_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ocmon_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int S = ocmon_pkg::LANE_STAGES;

  logic [S-1:0]                   v_r;
  logic [S-1:0]                   v_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [S:0]                     free;
  logic [S-1:0]                   go;
  logic [S-1:0]                   adv;
  logic [ocmon_pkg::THR_W-1:0]    thr_r;
  ocmon_pkg::ocmon_limits_t       lim_r;
  ocmon_pkg::amps_t               lane_amps [ocmon_pkg::NUM_CH];
  ocmon_pkg::amps_t               merged    [ocmon_pkg::NUM_CH];

  always_comb begin
    free[S] = !out_valid_r || !out_stall;
    for (int k = S - 1; k >= 0; k--) begin
      go[k]   = v_r[k] && free[k+1];
      free[k] = !v_r[k] || go[k];
    end
    for (int k = 0; k < S; k++) begin
      if (k == 0) begin
        adv[k] = in_valid && free[k];
      end else begin
        adv[k] = v_r[k-1] && free[k];
      end
      v_nxt[k] = adv[k] || (v_r[k] && !go[k]);
    end
    out_valid_nxt = go[S-1] || (out_valid_r && !free[S]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r              <= ocmon_pkg::RST_DISCONNECT;
      lim_r.dc_limit     <= ocmon_pkg::RST_DC_LIMIT;
      lim_r.inv_limit    <= ocmon_pkg::RST_INV_LIMIT;
      lim_r.consec_limit <= ocmon_pkg::RST_CONSEC;
    end else if (cfg_we) begin
      case (cfg_index)
        ocmon_pkg::REG_DISCONNECT: thr_r <= cfg_wdata[ocmon_pkg::THR_W-1:0];
        ocmon_pkg::REG_DC_LIMIT:   lim_r.dc_limit <= cfg_wdata[ocmon_pkg::AMPS_W-1:0];
        ocmon_pkg::REG_INV_LIMIT:  lim_r.inv_limit <= cfg_wdata[ocmon_pkg::AMPS_W-1:0];
        ocmon_pkg::REG_CONSEC:     lim_r.consec_limit <= cfg_wdata[ocmon_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ocmon_lane #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS),
    .INV       (1'b0)
  ) u_lane_dc_first (
    .clk  (clk),
    .adv  (adv),
    .raw  (in_raw_dc_first),
    .thr  (thr_r),
    .amps (lane_amps[ocmon_pkg::CH_DC_FIRST])
  );

  ocmon_lane #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS),
    .INV       (1'b0)
  ) u_lane_dc_second (
    .clk  (clk),
    .adv  (adv),
    .raw  (in_raw_dc_second),
    .thr  (thr_r),
    .amps (lane_amps[ocmon_pkg::CH_DC_SECOND])
  );

  ocmon_lane #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS),
    .INV       (1'b1)
  ) u_lane_inverter (
    .clk  (clk),
    .adv  (adv),
    .raw  (in_raw_inverter),
    .thr  (thr_r),
    .amps (lane_amps[ocmon_pkg::CH_INVERTER])
  );

  ocmon_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (go[S-1]),
    .amps_in  (lane_amps),
    .lim      (lim_r),
    .amps_out (merged),
    .trip     (out_trip)
  );

  assign in_stall           = !free[0];
  assign out_valid          = out_valid_r;
  assign out_amps_dc_first  = merged[ocmon_pkg::CH_DC_FIRST];
  assign out_amps_dc_second = merged[ocmon_pkg::CH_DC_SECOND];
  assign out_amps_inverter  = merged[ocmon_pkg::CH_INVERTER];

endmodule

// File: verif/three_channel_overcurrent_monitor_top_test.sv
// Self-checking test of three_channel_overcurrent_monitor_top: a directed table, then random
// bursts of ADC words under several threshold and limit settings, each word checked against a
// local current and trip predictor or typed value. Depends on ocmon_pkg and the monitor RTL.
module three_channel_overcurrent_monitor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ocmon_pkg::*;

  localparam longint unsigned FULL_CODE = 4095;
  localparam longint unsigned CODE_GAIN = 1419;
  localparam longint unsigned MID_GAIN  = 700;
  localparam longint unsigned DC_DIV    = 1750;
  localparam longint unsigned INV_DIV   = 175;
  localparam int NUM_PHASES = 9;

  typedef struct packed {
    amps_t dc_first;
    amps_t dc_second;
    amps_t inverter;
    logic  trip;
  } reading_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_WORD_TYPED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [11:0]        a;
    logic [11:0]        b;
    logic [11:0]        c;
    logic [IDX_W-1:0]   idx;
    logic [CFG_W-1:0]   data;
    reading_t           want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [11:0]       in_raw_dc_first = '0;
  logic [11:0]       in_raw_dc_second = '0;
  logic [11:0]       in_raw_inverter = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  amps_t             out_amps_dc_first;
  amps_t             out_amps_dc_second;
  amps_t             out_amps_inverter;
  logic              out_trip;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  logic [11:0]       thr_reg;
  amps_t             dc_lim;
  amps_t             inv_lim;
  logic [7:0]        consec_reg;
  logic [7:0]        over_streak [NUM_CH];

  reading_t          expected_readings [$];
  plan_row_t         directed_plan [$];
  int                mismatch_count = 0;
  int                send_gap_pct = 0;
  int                recv_stall_pct = 0;
  int                send_calm = 0;
  int                recv_calm = 0;
  int                phase_words [NUM_PHASES] = '{150, 150, 120, 120, 400, 150, 150, 150, 150};

  three_channel_overcurrent_monitor_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_dc_first   (in_raw_dc_first),
    .in_raw_dc_second  (in_raw_dc_second),
    .in_raw_inverter   (in_raw_inverter),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_amps_dc_first (out_amps_dc_first),
    .out_amps_dc_second(out_amps_dc_second),
    .out_amps_inverter (out_amps_inverter),
    .out_trip          (out_trip),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic amps_t scaled_amps(input logic [11:0] code, input bit inverter_ch);
    longint unsigned hi, lo, span, q;
    hi = CODE_GAIN * code;
    lo = MID_GAIN * FULL_CODE;
    span = (hi >= lo) ? hi - lo : lo - hi;
    if (inverter_ch) q = (span << 17) / (INV_DIV * FULL_CODE);
    else q = (span << 16) / (DC_DIV * FULL_CODE);
    if (q > 64'hFFFFF) q = 64'hFFFFF;
    return amps_t'(q);
  endfunction

  function automatic amps_t channel_amps(input logic [11:0] code, input bit inverter_ch);
    if (code < thr_reg) return '0;
    return scaled_amps(code, inverter_ch);
  endfunction

  function automatic bit advance_streak(input int ch, input amps_t amps, input amps_t limit);
    if (amps > limit) begin
      if (over_streak[ch] != 8'hFF) over_streak[ch] = over_streak[ch] + 8'd1;
      return over_streak[ch] >= consec_reg;
    end
    over_streak[ch] = '0;
    return 1'b0;
  endfunction

  function automatic reading_t predict_reading(input logic [11:0] a, b, c);
    reading_t r;
    bit t0, t1, t2;
    r.dc_first  = channel_amps(a, 1'b0);
    r.dc_second = channel_amps(b, 1'b0);
    r.inverter  = channel_amps(c, 1'b1);
    t0 = advance_streak(CH_DC_FIRST, r.dc_first, dc_lim);
    t1 = advance_streak(CH_DC_SECOND, r.dc_second, dc_lim);
    t2 = advance_streak(CH_INVERTER, r.inverter, inv_lim);
    r.trip = t0 | t1 | t2;
    return r;
  endfunction

  function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_DISCONNECT: thr_reg = data[11:0];
      REG_DC_LIMIT:   dc_lim = data[AMPS_W-1:0];
      REG_INV_LIMIT:  inv_lim = data[AMPS_W-1:0];
      REG_CONSEC:     consec_reg = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    thr_reg = '0;
    dc_lim = 20'hFFFFF;
    inv_lim = 20'hFFFFF;
    consec_reg = 8'd3;
    foreach (over_streak[ch]) over_streak[ch] = '0;
  endfunction

  function automatic bit sender_gap();
    if (send_calm > 0) begin
      send_calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 49) == 0) begin
      send_calm = $urandom_range(10, 40);
      return 1'b0;
    end
    return $urandom_range(0, 99) < send_gap_pct;
  endfunction

  always @(negedge clk) begin : recv_throttle
    bit stall_now;
    stall_now = 1'b0;
    if (recv_calm > 0) begin
      recv_calm--;
    end else if ($urandom_range(0, 49) == 0) begin
      recv_calm = $urandom_range(10, 40);
    end else begin
      stall_now = $urandom_range(0, 99) < recv_stall_pct;
    end
    out_stall <= stall_now;
  end

  task automatic compare_field(input string label, input logic [AMPS_W-1:0] want, got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("mismatch %s: expected %0d, got %0d", label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : reading_check
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected word: %0d %0d %0d trip %0d", out_amps_dc_first,
                   out_amps_dc_second, out_amps_inverter, out_trip);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        compare_field("amps_dc_first", want.dc_first, out_amps_dc_first);
        compare_field("amps_dc_second", want.dc_second, out_amps_dc_second);
        compare_field("amps_inverter", want.inverter, out_amps_inverter);
        compare_field("trip", AMPS_W'(want.trip), AMPS_W'(out_trip));
      end
    end
  end

  task automatic send_word(input logic [11:0] a, b, c, input bit typed, input reading_t typed_val);
    reading_t predicted;
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_dc_first <= a;
    in_raw_dc_second <= b;
    in_raw_inverter <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_reading(a, b, c);
    expected_readings.push_back(typed ? typed_val : predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_word(input logic [11:0] a, b, c);
    directed_plan.push_back('{ROW_WORD, a, b, c, '0, '0, '0});
  endfunction

  function automatic void add_typed(input logic [11:0] a, b, c, input amps_t e0, e1, e2,
                                    input logic et);
    reading_t r;
    r = '{e0, e1, e2, et};
    directed_plan.push_back('{ROW_WORD_TYPED, a, b, c, '0, '0, r});
  endfunction

  function automatic void add_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    directed_plan.push_back('{ROW_CFG, '0, '0, '0, idx, data, '0});
  endfunction

  function automatic void build_directed();
    add_typed(12'd0, 12'd4095, 12'd0, 20'd26214, 20'd26925, 20'd524288, 1'b0);
    add_typed(12'd4095, 12'd0, 12'd4095, 20'd26925, 20'd26214, 20'd538518, 1'b0);
    add_word(12'd2020, 12'd2021, 12'd2020);
    add_word(12'd1, 12'd4094, 12'd2048);
    add_word(12'hAAA, 12'h555, 12'hFFF);
    add_cfg(REG_DISCONNECT, 20'd2048);
    add_typed(12'd2047, 12'd0, 12'd2047, 20'd0, 20'd0, 20'd0, 1'b0);
    add_word(12'd2048, 12'd4095, 12'd2048);
    add_cfg(REG_DISCONNECT, 20'd4095);
    add_typed(12'd4094, 12'd4095, 12'd4094, 20'd0, 20'd26925, 20'd0, 1'b0);
    add_cfg(REG_DISCONNECT, 20'd0);
    add_cfg(REG_DC_LIMIT, 20'd26214);
    add_cfg(REG_INV_LIMIT, 20'd524288);
    add_word(12'd0, 12'd0, 12'd0);
    add_word(12'd4095, 12'd0, 12'd0);
    add_word(12'd4095, 12'd0, 12'd0);
    add_word(12'd4095, 12'd0, 12'd0);
    add_word(12'd0, 12'd0, 12'd0);
    add_cfg(REG_CONSEC, 20'd0);
    add_word(12'd4095, 12'd0, 12'd0);
    add_word(12'd0, 12'd0, 12'd4095);
    add_cfg(REG_DC_LIMIT, 20'd0);
    add_cfg(REG_INV_LIMIT, 20'd0);
    add_word(12'd2020, 12'd2020, 12'd2020);
    add_cfg(REG_DC_LIMIT, 20'hFFFFF);
    add_cfg(REG_INV_LIMIT, 20'hFFFFF);
    add_cfg(REG_CONSEC, 20'd255);
    add_typed(12'd4095, 12'd4095, 12'd4095, 20'd26925, 20'd26925, 20'd538518, 1'b0);
    add_cfg(REG_CONSEC, 20'd3);
  endfunction

  task automatic program_phase(input int phase);
    logic [CFG_W-1:0] thr, dc, inv, cons;
    case (phase)
      0: begin
        thr = 20'd0; dc = 20'd13000; inv = 20'd260000; cons = 20'd3;
      end
      1: begin
        thr = CFG_W'($urandom_range(0, 2047));
        dc = scaled_amps(12'($urandom_range(0, 4095)), 1'b0);
        inv = scaled_amps(12'($urandom_range(0, 4095)), 1'b1);
        cons = CFG_W'($urandom_range(0, 8));
      end
      2: begin
        thr = 20'd4095; dc = 20'd0; inv = 20'd0; cons = 20'd0;
      end
      3: begin
        thr = 20'd0; dc = 20'hFFFFF; inv = 20'hFFFFF; cons = 20'd255;
      end
      4: begin
        thr = 20'd0; dc = 20'd100; inv = 20'd2000; cons = 20'd255;
      end
      default: begin
        thr = $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 600))
                                   : CFG_W'($urandom_range(0, 4095));
        dc = $urandom_range(0, 1) ? scaled_amps(12'($urandom_range(0, 4095)), 1'b0)
                                  : CFG_W'($urandom);
        inv = $urandom_range(0, 1) ? scaled_amps(12'($urandom_range(0, 4095)), 1'b1)
                                   : CFG_W'($urandom);
        cons = CFG_W'($urandom_range(0, 12));
      end
    endcase
    if ($urandom_range(0, 1)) begin
      thr[19:12] = 8'($urandom);
      cons[19:8] = 12'($urandom);
    end
    write_reg(REG_DISCONNECT, thr);
    write_reg(REG_DC_LIMIT, dc);
    write_reg(REG_INV_LIMIT, inv);
    write_reg(REG_CONSEC, cons);
  endtask

  function automatic logic [11:0] pick_code(input int band);
    int v;
    case (band)
      3, 4: return $urandom_range(0, 1) ? 12'($urandom_range(0, 400))
                                        : 12'($urandom_range(3695, 4095));
      5, 6: return 12'($urandom_range(1900, 2140));
      7: begin
        v = int'(thr_reg) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
      end
      8: return $urandom_range(0, 1) ? 12'd0 : 12'd4095;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send_phase_words(input int count, input bit deep_runs);
    int left, burst;
    int band [NUM_CH];
    logic [11:0] code [NUM_CH];
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      foreach (band[ch]) band[ch] = deep_runs ? $urandom_range(0, 4) : $urandom_range(0, 9);
      for (int k = 0; k < burst && left > 0; k++) begin
        foreach (code[ch]) code[ch] = pick_code(band[ch]);
        send_word(code[0], code[1], code[2], 1'b0, '0);
        left--;
      end
    end
  endtask

  initial begin : stimulus
    plan_row_t row;
    reset_model();
    send_gap_pct = 21;
    recv_stall_pct = 47;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    build_directed();
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_word(row.a, row.b, row.c, row.kind == ROW_WORD_TYPED, row.want);
      end
    end
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 3) begin
        send_gap_pct = 47;
        recv_stall_pct = 21;
      end
      if (phase == 6) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      settle();
      program_phase(phase);
      send_phase_words(phase_words[phase], phase == 4);
    end
    settle();
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
